// ----- src/sfoi_pkg.sv -----
// ----------------------------------------------------------------------------
// sfoi_pkg
// Shared types, constants and the CORDIC arctangent table of the serial
// frame odometry integrator.
// ----------------------------------------------------------------------------
package sfoi_pkg;

  localparam int FRAME_LEN_DEF    = 10;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_MAX_STEPS = 24;

  localparam logic [7:0]  SYNC_BYTE = 8'hA2;
  localparam logic [7:0]  TAIL_BYTE = 8'h2A;

  localparam logic [31:0] DPP_RESET  = 32'd2633960;
  localparam logic [15:0] MAXP_RESET = 16'd30000;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DPP  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAXP = 1'd1;

  // angle arithmetic
  localparam int NUM_W = 20;
  localparam logic signed [18:0] HALF_TURN = 19'sd1800;
  localparam logic signed [18:0] FULL_TURN = 19'sd3600;
  localparam logic signed [20:0] ANG_OFFSET = 21'sd288000;
  localparam logic [13:0] TURN_HT  = 14'd7200;
  localparam logic [31:0] BA_ROUND = 32'd3600;

  localparam int CW = 34;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    logic        good;
    logic        at_tail;
    logic [15:0] angle;
    logic [15:0] pulse;
  } frm_evt_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

// ----- src/serial_frame_odometry_integrator.sv -----
// ----------------------------------------------------------------------------
// serial_frame_odometry_integrator
// Frame parser and dead-reckoning pose integrator for a serial odometry link.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while a frame is collected, unless the tail
// byte is held. A good frame (FRAME_LEN bytes, sync to good tail) starts a
// pose update: a prepare step, a bit-serial angle reduction and the CORDIC
// iterations beside a bit-serial travel multiply, a bit-serial multiply for
// the position increments and an accumulate step. While the update runs or
// its result waits, further bytes are still taken up to the tail byte of
// the next frame, which waits for the update and the result transaction to
// finish. One result transaction follows each good frame.
module serial_frame_odometry_integrator
  import sfoi_pkg::*;
#(
  parameter int FRAME_LEN    = FRAME_LEN_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [47:0]   out_pos_x,
  output logic signed [47:0]   out_pos_y,
  output logic signed [16:0]   out_heading,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_ROT  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_ACC  = 3'd4;

  frm_evt_t evt;
  logic     in_acc;

  logic [2:0]        st_r, st_nxt;
  logic [31:0]       dpp_r;
  logic [15:0]       maxp_r;
  logic [15:0]       fa_r, fp_r;
  logic              started_r;
  logic [15:0]       ref_r, lp_r;
  logic signed [17:0] lh_r;
  logic [63:0]       acc_x_r, acc_y_r;
  logic signed [16:0] rel_r;
  logic [NUM_W-1:0]  num_r;
  logic signed [15:0] dp_r;
  logic              go1_r, go2_r;
  logic              rot_ok_r, dist_ok_r;
  logic              out_valid_r;

  // prepare
  logic [15:0]        s_ang, eff_ref, eff_lp, dpraw, dpsub, dpadd;
  logic signed [16:0] rel, half, dp17;
  logic signed [18:0] dh, dhw;
  logic signed [20:0] ang, num_s;
  logic signed [15:0] dp;

  assign s_ang   = 16'h0 - fa_r;
  assign eff_ref = started_r ? ref_r : s_ang;
  assign eff_lp  = started_r ? lp_r : fp_r;
  assign rel     = 17'($signed(s_ang)) - 17'($signed(eff_ref));
  assign dh      = 19'(rel) - 19'(lh_r);
  assign dhw     = (dh > HALF_TURN) ? dh - FULL_TURN :
                   (dh < -HALF_TURN) ? dh + FULL_TURN : dh;
  assign ang     = 21'(lh_r) + 21'(lh_r) + 21'(dhw) + 21'(HALF_TURN);
  assign num_s   = ang + ANG_OFFSET;

  assign dpraw = fp_r - eff_lp;
  assign dp17  = 17'($signed(dpraw));
  assign half  = $signed({2'b00, maxp_r[15:1]});
  assign dpsub = dpraw - maxp_r;
  assign dpadd = dpraw + maxp_r;
  assign dp    = (dp17 > half) ? $signed(dpsub) :
                 (dp17 < -half) ? $signed(dpadd) : $signed(dpraw);

  // units
  logic                 rot_done, dist_done, mx_done, my_done;
  logic signed [CW-1:0] cq, sq;
  logic [49:0]          dprod;
  logic signed [47:0]   travel;
  logic [82:0]          px, py;
  logic [47:0]          incx, incy;

  assign in_ready = !(evt.at_tail && ((st_r != S_IDLE) || out_valid_r));
  assign in_acc   = in_valid && in_ready;

  sfoi_framer #(.FRAME_LEN(FRAME_LEN)) u_framer (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_acc),
    .rx_byte (in_rx_byte),
    .evt     (evt)
  );

  sfoi_rotor #(.STEPS(CORDIC_STEPS)) u_rotor (
    .clk   (clk),
    .rst_n (rst_n),
    .start (go1_r),
    .num   (num_r),
    .done  (rot_done),
    .cos_q (cq),
    .sin_q (sq)
  );

  sfoi_sermul #(.AW(33), .BW(16)) u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .start (go1_r),
    .a     ($signed({1'b0, dpp_r})),
    .b     (dp_r),
    .done  (dist_done),
    .prod  (dprod)
  );

  assign travel = $signed(dprod[47:0]);

  sfoi_sermul #(.AW(48), .BW(CW)) u_mx (
    .clk   (clk),
    .rst_n (rst_n),
    .start (go2_r),
    .a     (travel),
    .b     (cq),
    .done  (mx_done),
    .prod  (px)
  );

  sfoi_sermul #(.AW(48), .BW(CW)) u_my (
    .clk   (clk),
    .rst_n (rst_n),
    .start (go2_r),
    .a     (travel),
    .b     (sq),
    .done  (my_done),
    .prod  (py)
  );

  assign incx = px[81:34] + {47'd0, px[33]};
  assign incy = py[81:34] + {47'd0, py[33]};

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (evt.good) st_nxt = S_PREP;
      S_PREP: st_nxt = S_ROT;
      S_ROT:  if (rot_ok_r && dist_ok_r) st_nxt = S_MUL;
      S_MUL:  if (mx_done && my_done) st_nxt = S_ACC;
      S_ACC:  st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      dpp_r       <= DPP_RESET;
      maxp_r      <= MAXP_RESET;
      started_r   <= 1'b0;
      ref_r       <= '0;
      lp_r        <= '0;
      lh_r        <= '0;
      acc_x_r     <= '0;
      acc_y_r     <= '0;
      go1_r       <= 1'b0;
      go2_r       <= 1'b0;
      rot_ok_r    <= 1'b0;
      dist_ok_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      go1_r <= (st_r == S_PREP);
      go2_r <= (st_r == S_ROT) && rot_ok_r && dist_ok_r;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DPP:  dpp_r  <= cfg_data;
          REG_MAXP: maxp_r <= cfg_data[15:0];
          default:  ;
        endcase
      end
      if (st_r == S_PREP) begin
        started_r <= 1'b1;
        ref_r     <= eff_ref;
        lp_r      <= fp_r;
        lh_r      <= 18'(rel);
        rot_ok_r  <= 1'b0;
        dist_ok_r <= 1'b0;
      end else begin
        if (rot_done)  rot_ok_r  <= 1'b1;
        if (dist_done) dist_ok_r <= 1'b1;
      end
      if (st_r == S_ACC) begin
        acc_x_r     <= acc_x_r + {{16{incx[47]}}, incx};
        acc_y_r     <= acc_y_r + {{16{incy[47]}}, incy};
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && evt.good) begin
      fa_r <= evt.angle;
      fp_r <= evt.pulse;
    end
    if (st_r == S_PREP) begin
      rel_r <= rel;
      num_r <= num_s[NUM_W-1:0];
      dp_r  <= dp;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_pos_x   = $signed(acc_x_r[63:16]);
  assign out_pos_y   = $signed(acc_y_r[63:16]);
  assign out_heading = rel_r;

endmodule

// ----- src/sfoi_framer.sv -----
// ----------------------------------------------------------------------------
// sfoi_framer
// Sync hunt and frame collection; flags a frame whose tail byte is good.
// ----------------------------------------------------------------------------
module sfoi_framer
  import sfoi_pkg::*;
#(
  parameter int FRAME_LEN = FRAME_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output frm_evt_t   evt
);

  localparam int IW = $clog2(FRAME_LEN);

  logic [IW-1:0] idx_r, idx_nxt;
  logic [15:0]   ang_r, ang_nxt;
  logic [15:0]   pul_r, pul_nxt;
  logic          tail;

  assign tail = (idx_r == IW'(FRAME_LEN - 1));

  always_comb begin
    idx_nxt = idx_r;
    ang_nxt = ang_r;
    pul_nxt = pul_r;
    if (accept) begin
      if (idx_r == '0) begin
        if (rx_byte == SYNC_BYTE) idx_nxt = IW'(1);
      end else begin
        if (idx_r == IW'(FRAME_LEN - 5)) ang_nxt[7:0]  = rx_byte;
        if (idx_r == IW'(FRAME_LEN - 4)) ang_nxt[15:8] = rx_byte;
        if (idx_r == IW'(FRAME_LEN - 3)) pul_nxt[7:0]  = rx_byte;
        if (idx_r == IW'(FRAME_LEN - 2)) pul_nxt[15:8] = rx_byte;
        idx_nxt = tail ? '0 : idx_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      ang_r <= '0;
      pul_r <= '0;
    end else begin
      idx_r <= idx_nxt;
      ang_r <= ang_nxt;
      pul_r <= pul_nxt;
    end
  end

  assign evt.good    = accept && tail && (rx_byte == TAIL_BYTE);
  assign evt.at_tail = tail;
  assign evt.angle   = ang_r;
  assign evt.pulse   = pul_r;

endmodule

// ----- src/sfoi_sermul.sv -----
// ----------------------------------------------------------------------------
// sfoi_sermul
// Bit-serial signed multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module sfoi_sermul #(
  parameter int AW = 48,
  parameter int BW = 34
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic                 done,
  output logic [AW+BW:0]       prod
);

  localparam int NW = $clog2(BW + 1);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [NW-1:0]        cnt_r, cnt_nxt;
  logic signed [AW-1:0] a_r, a_nxt;
  logic [BW-1:0]        b_r, b_nxt;
  logic [AW:0]          h_r, h_nxt;
  logic [BW-1:0]        l_r, l_nxt;
  logic [AW+1:0]        a_ext, sel, sum;
  logic                 last;

  assign last  = (cnt_r == NW'(BW - 1));
  assign a_ext = {{2{a_r[AW-1]}}, a_r};
  assign sel   = b_r[0] ? (last ? (~a_ext + 1'b1) : a_ext) : '0;
  assign sum   = {h_r[AW], h_r} + sel;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    h_nxt    = h_r;
    l_nxt    = l_r;
    if (busy_r) begin
      h_nxt   = sum[AW+1:1];
      l_nxt   = {sum[0], l_r[BW-1:1]};
      b_nxt   = b_r >> 1;
      cnt_nxt = cnt_r + NW'(1);
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      a_nxt    = a;
      b_nxt    = b;
      h_nxt    = '0;
      l_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    h_r <= h_nxt;
    l_r <= l_nxt;
  end

  assign done = done_r;
  assign prod = {h_r, l_r};

endmodule

// ----- src/sfoi_rotor.sv -----
// ----------------------------------------------------------------------------
// sfoi_rotor
// Serial angle reduction to a binary angle, then iterative CORDIC rotation
// giving cos and sin in Q30.
// ----------------------------------------------------------------------------
module sfoi_rotor
  import sfoi_pkg::*;
#(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [NUM_W-1:0]     num,
  output logic                 done,
  output logic signed [CW-1:0] cos_q,
  output logic signed [CW-1:0] sin_q
);

  localparam int NSTEP   = (STEPS < CORDIC_MAX_STEPS) ? STEPS : CORDIC_MAX_STEPS;
  localparam int DIV_LEN = NUM_W + 32;

  localparam logic [1:0] R_IDLE = 2'd0;
  localparam logic [1:0] R_DIV  = 2'd1;
  localparam logic [1:0] R_FLIP = 2'd2;
  localparam logic [1:0] R_ROT  = 2'd3;

  logic [1:0]           st_r, st_nxt;
  logic                 done_r, done_nxt;
  logic [5:0]           cnt_r, cnt_nxt;
  logic [DIV_LEN-1:0]   sh_r, sh_nxt;
  logic [12:0]          rem_r, rem_nxt;
  logic [31:0]          q_r, q_nxt;
  logic                 flip_r, flip_nxt;
  logic signed [CW-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [13:0]          trial, tsub;
  logic                 ge;
  logic [31:0]          ba;
  logic signed [CW-1:0] dx, dy, at;

  assign trial = {rem_r, sh_r[DIV_LEN-1]};
  assign ge    = (trial >= TURN_HT);
  assign tsub  = trial - TURN_HT;
  assign ba    = (q_r[31] ^ q_r[30]) ? {~q_r[31], q_r[30:0]} : q_r;
  assign dx    = y_r >>> cnt_r[4:0];
  assign dy    = x_r >>> cnt_r[4:0];
  assign at    = CW'(atan_turn(cnt_r[4:0]));

  always_comb begin
    st_nxt   = st_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    flip_nxt = flip_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    unique case (st_r)
      R_IDLE: begin
        if (start) begin
          st_nxt  = R_DIV;
          cnt_nxt = '0;
          sh_nxt  = {num, BA_ROUND};
          rem_nxt = '0;
        end
      end
      R_DIV: begin
        rem_nxt = ge ? tsub[12:0] : trial[12:0];
        q_nxt   = {q_r[30:0], ge};
        sh_nxt  = sh_r << 1;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(DIV_LEN - 1)) st_nxt = R_FLIP;
      end
      R_FLIP: begin
        flip_nxt = q_r[31] ^ q_r[30];
        x_nxt    = CORDIC_GAIN;
        y_nxt    = '0;
        z_nxt    = CW'($signed(ba));
        cnt_nxt  = '0;
        st_nxt   = R_ROT;
      end
      R_ROT: begin
        if (!z_r[CW-1]) begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - at;
        end else begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + at;
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(NSTEP - 1)) begin
          st_nxt   = R_IDLE;
          done_nxt = 1'b1;
        end
      end
      default: st_nxt = R_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= R_IDLE;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r   <= sh_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    flip_r <= flip_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
  end

  assign done  = done_r;
  assign cos_q = flip_r ? -x_r : x_r;
  assign sin_q = flip_r ? -y_r : y_r;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the serial frame odometry integrator. Byte streams
// of well-formed frames with random heading and pulse steps, mixed with bad
// tails, cut frames and noise, are sent in bursts under several register
// settings. A scoreboard predicts each pose result and checks it in order.
// ----------------------------------------------------------------------------
module tb_top;
  import sfoi_pkg::*;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int SETTLE_CYCLES = 200;

  typedef struct {
    logic [47:0] pos_x;
    logic [47:0] pos_y;
    logic [16:0] heading;
  } pose_t;

  class pose_scoreboard;
    pose_t       pose_q[$];
    int          errors;
    longint      dpp;
    longint      maxp;
    int          byte_pos;
    logic [15:0] raw_angle;
    logic [15:0] raw_pulse;
    bit          locked;
    logic [15:0] angle_ref;
    logic [15:0] prev_pulse;
    longint      prev_heading;
    bit [63:0]   sum_x;
    bit [63:0]   sum_y;
    longint      atan_tbl[16];

    function new();
      atan_tbl = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                   64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                   64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
                   64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};
      errors = 0;
      dpp = 2633960;
      maxp = 30000;
      byte_pos = 0;
      raw_angle = '0;
      raw_pulse = '0;
      locked = 0;
      angle_ref = '0;
      prev_pulse = '0;
      prev_heading = 0;
      sum_x = '0;
      sum_y = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      if (idx == REG_DPP) dpp = longint'({32'd0, val});
      else if (idx == REG_MAXP) maxp = longint'({16'd0, val[15:0]});
    endfunction

    function longint sext16(logic [15:0] v);
      return longint'($signed(v));
    endfunction

    function void rotate(longint ang, output longint c, output longint s);
      longint    r, x, y, z, dx, dy;
      bit [63:0] t;
      bit [31:0] ba;
      bit        flip;
      r = ang % 7200;
      if (r < 0) r += 7200;
      t = (64'(r) << 32) + 64'd3600;
      t = t / 64'd7200;
      ba = t[31:0];
      flip = 0;
      if (ba >= 32'h40000000 && ba < 32'hC0000000) begin
        ba += 32'h80000000;
        flip = 1;
      end
      z = longint'($signed(ba));
      x = 652032874;
      y = 0;
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_tbl[i];
        end else begin
          x += dx; y -= dy; z += atan_tbl[i];
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function bit [63:0] scale(longint d, longint q);
      longint hi, lo, a, b, aq, ar, rem;
      hi = d >>> 16;
      lo = d & 64'hFFFF;
      a = hi * q;
      b = lo * q;
      aq = a >>> 18;
      ar = a - aq * 262144;
      rem = ar * 65536 + b + 64'sh2_0000_0000;
      return 64'(aq + (rem >>> 34));
    endfunction

    function void integrate();
      logic [15:0] neg;
      longint      rel, dh, dp, half, travel, c, s;
      pose_t       p;
      neg = 16'd0 - raw_angle;
      if (!locked) begin
        locked = 1;
        prev_pulse = raw_pulse;
        angle_ref = neg;
      end
      rel = sext16(neg) - sext16(angle_ref);
      dh = rel - prev_heading;
      if (dh > 1800) dh -= 3600;
      else if (dh < -1800) dh += 3600;
      rotate(2 * prev_heading + dh + 1800, c, s);
      prev_heading = rel;
      dp = sext16(raw_pulse - prev_pulse);
      half = maxp / 2;
      if (dp > half) dp = sext16(16'(dp - maxp));
      else if (dp < -half) dp = sext16(16'(dp + maxp));
      prev_pulse = raw_pulse;
      travel = dp * dpp;
      sum_x += scale(travel, c);
      sum_y += scale(travel, s);
      p.pos_x = sum_x[63:16];
      p.pos_y = sum_y[63:16];
      p.heading = rel[16:0];
      pose_q.push_back(p);
    endfunction

    function void note_byte(logic [7:0] b);
      if (byte_pos == 0) begin
        if (b == SYNC_BYTE) byte_pos = 1;
        return;
      end
      case (byte_pos)
        5: raw_angle[7:0] = b;
        6: raw_angle[15:8] = b;
        7: raw_pulse[7:0] = b;
        8: raw_pulse[15:8] = b;
        default: ;
      endcase
      if (byte_pos >= 9) begin
        byte_pos = 0;
        if (b == TAIL_BYTE) integrate();
      end else begin
        byte_pos++;
      end
    endfunction

    task report(string what, logic [47:0] got, logic [47:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check(logic [47:0] x, logic [47:0] y, logic [16:0] h);
      pose_t e;
      if (pose_q.size() == 0) begin
        report("unexpected transaction", x, '0);
        return;
      end
      e = pose_q.pop_front();
      if (x !== e.pos_x) report("pos_x", x, e.pos_x);
      if (y !== e.pos_y) report("pos_y", y, e.pos_y);
      if (h !== e.heading) report("heading", 48'(h), 48'(e.heading));
    endtask
  endclass

  logic                 clk = 0;
  logic                 rst_n = 0;
  logic                 in_valid = 0;
  logic                 in_ready;
  logic [7:0]           in_rx_byte = '0;
  logic                 out_valid;
  logic                 out_ready = 0;
  logic signed [47:0]   out_pos_x;
  logic signed [47:0]   out_pos_y;
  logic signed [16:0]   out_heading;
  logic                 cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  pose_scoreboard sb = new();
  int             cycles = 0;
  int             burst_left = 0;
  int             stall_mode = 0;
  int             stall_left = 0;
  logic [15:0]    gen_angle = '0;
  logic [15:0]    gen_pulse = '0;

  serial_frame_odometry_integrator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_heading(out_heading),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 300);
    end
    stall_left--;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      2: out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check(out_pos_x, out_pos_y, out_heading);
  end

  task send_byte(logic [7:0] b);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(b);
    burst_left--;
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.pose_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // len < 10 cuts the frame short; the following bytes then fill it up
  task send_frame(logic [15:0] ang, logic [15:0] pls, logic [7:0] tail, int len);
    logic [7:0] fb[10];
    fb[0] = SYNC_BYTE;
    for (int i = 1; i < 5; i++)
      fb[i] = ($urandom_range(0, 5) == 0) ? SYNC_BYTE : 8'($urandom);
    fb[5] = ang[7:0];
    fb[6] = ang[15:8];
    fb[7] = pls[7:0];
    fb[8] = pls[15:8];
    fb[9] = tail;
    for (int i = 0; i < len; i++) send_byte(fb[i]);
  endtask

  task random_frame();
    int kind, step, mp, np;
    kind = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0: gen_angle = 16'($urandom);
      1, 2: gen_angle = gen_angle + 16'($urandom_range(1500, 2100)) *
                        (($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'd1);
      default: gen_angle = gen_angle + 16'($signed($urandom_range(0, 600)) - 300);
    endcase
    mp = int'(sb.maxp);
    if ($urandom_range(0, 9) == 0) begin
      gen_pulse = 16'($urandom);
    end else begin
      step = $signed($urandom_range(0, mp)) - mp / 2;
      np = (int'(gen_pulse) + step) % mp;
      if (np < 0) np += mp;
      gen_pulse = 16'(np);
    end
    if (kind < 80)
      send_frame(gen_angle, gen_pulse, TAIL_BYTE, 10);
    else if (kind < 88)
      send_frame(gen_angle, gen_pulse, 8'($urandom_range(0, 255)), 10);
    else if (kind < 93)
      send_frame(gen_angle, gen_pulse, TAIL_BYTE, $urandom_range(1, 9));
    else
      repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: first frame, heading wrap, bad tail, byte extremes
    send_frame(16'd1790, 16'd29990, TAIL_BYTE, 10);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(16'hF902, 16'd5, TAIL_BYTE, 10);
    send_frame(16'd1795, 16'hFFFF, 8'hFF, 10);
    send_frame(16'hFFFF, 16'd0, TAIL_BYTE, 10);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_DPP, 32'hFFFFFFFF);
          write_reg(REG_MAXP, 16'd2);
        end
        1: begin
          write_reg(REG_DPP, 32'd0);
          write_reg(REG_MAXP, 16'd32768);
        end
        2: begin
          write_reg(REG_DPP, $urandom);
          write_reg(REG_MAXP, $urandom_range(2, 32768));
        end
        3: begin
          write_reg(REG_DPP, $urandom_range(1, 100000000));
          write_reg(REG_MAXP, 16'd3);
        end
        default: begin
          write_reg(REG_DPP, DPP_RESET);
          write_reg(REG_MAXP, MAXP_RESET);
        end
      endcase
      gen_pulse = '0;
      repeat (22) random_frame();
      drain();
    end

    if (sb.errors == 0 && sb.pose_q.size() == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
